/* hw/rtl/drlf_pkg.sv */
// drlf_pkg: shared widths, config register codes, event and config types
// used by every file of the dark row line finder; no dependencies
package drlf_pkg;

  localparam int MAX_PENDING = 8;
  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = $clog2(MAX_DIM) + 1;
  localparam int ROW_W       = $clog2(MAX_DIM);
  localparam int PIX_W       = 8;
  localparam int SUM_W       = 20;
  localparam int GAP_W       = 8;
  localparam int EVQ_DEPTH   = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SUM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_BAND_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_BAND_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LINE_GAP      = 3'd6;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH       = 13'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT      = 13'd480;
  localparam logic [SUM_W-1:0] RST_DARK_THRESHOLD    = 20'd32640;
  localparam logic [SUM_W-1:0] RST_BRIGHT_THRESHOLD  = 20'd130560;
  localparam logic [DIM_W-1:0] RST_TOP_BAND_LIMIT    = 13'd96;
  localparam logic [DIM_W-1:0] RST_BOTTOM_BAND_LIMIT = 13'd408;
  localparam logic [GAP_W-1:0] RST_MIN_LINE_GAP      = 8'd8;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [SUM_W-1:0] dark_threshold;
    logic [SUM_W-1:0] bright_threshold;
    logic [DIM_W-1:0] top_band_limit;
    logic [DIM_W-1:0] bottom_band_limit;
    logic [GAP_W-1:0] min_line_gap;
  } cfg_t;

  // one row verdict handed from front to back
  typedef struct packed {
    logic             add;
    logic             flush;
    logic [ROW_W-1:0] row;
    logic [DIM_W-1:0] base;
    logic             overflow;
  } event_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    return res;
  endfunction

endpackage

/* hw/rtl/drlf_pix_if.sv */
// drlf_pix_if: valid/ready channel carrying one 8-bit pixel per beat
// depends on drlf_pkg
interface drlf_pix_if;
  logic                       valid;
  logic                       ready;
  logic [drlf_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

/* hw/rtl/drlf_line_if.sv */
// drlf_line_if: valid/ready channel carrying one detected line per beat
// depends on drlf_pkg
interface drlf_line_if;
  logic                       valid;
  logic                       ready;
  logic [drlf_pkg::ROW_W-1:0] line_start;
  logic [drlf_pkg::DIM_W-1:0] line_thickness;
  logic                       last_of_run;
  logic                       overflow;
  modport source (output valid, output line_start, output line_thickness,
                  output last_of_run, output overflow, input ready);
  modport sink (input valid, input line_start, input line_thickness,
                input last_of_run, input overflow, output ready);
endinterface

/* hw/rtl/drlf_front.sv */
// drlf_front: row summing, dark/bright classification, spacing and queue bookkeeping
// emits one event per row that adds a start or flushes; depends on drlf_pkg
module drlf_front #(
  parameter int MaxPending = drlf_pkg::MAX_PENDING
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  drlf_pkg::cfg_t             cfg,
  input  logic                       pix_accept,
  input  logic [drlf_pkg::PIX_W-1:0] pixel,
  output drlf_pkg::event_t           ev,
  output logic                       ev_push
);

  localparam int CNT_W = $clog2(MaxPending + 1);
  localparam int ROW_W = drlf_pkg::ROW_W;
  localparam int DIM_W = drlf_pkg::DIM_W;
  localparam int SUM_W = drlf_pkg::SUM_W;

  logic [ROW_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [ROW_W-1:0] last_r, last_nxt;
  logic             have_r, have_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic [DIM_W-1:0] w, h, col_inc, row_inc, row_ext, gap_lim;
  logic [SUM_W-1:0] sum_acc;
  logic             row_end, bright, dark, in_band, spaced, img_end;
  logic             can_add, want_add, do_add, flush;
  logic [CNT_W-1:0] pcnt_added;

  always_comb begin
    w        = drlf_pkg::clamp_dim(cfg.image_width);
    h        = drlf_pkg::clamp_dim(cfg.image_height);
    sum_acc  = sum_r + SUM_W'(pixel);
    col_inc  = DIM_W'(col_r) + DIM_W'(1);
    row_end  = col_inc >= w;
    row_ext  = DIM_W'(row_r);
    row_inc  = row_ext + DIM_W'(1);
    img_end  = row_inc >= h;
    bright   = sum_acc > cfg.bright_threshold;
    dark     = sum_acc < cfg.dark_threshold;
    in_band  = (row_ext < cfg.top_band_limit) || (row_ext > cfg.bottom_band_limit);
    gap_lim  = DIM_W'(last_r) + DIM_W'(cfg.min_line_gap);
    spaced   = have_r ? (row_ext > gap_lim) : (row_r >= ROW_W'(2));
    can_add  = pcnt_r < CNT_W'(MaxPending);
    want_add = !bright && dark && in_band && spaced;
    do_add   = want_add && can_add;
    pcnt_added = do_add ? pcnt_r + CNT_W'(1) : pcnt_r;
    flush    = bright ? (pcnt_r != '0) : (img_end && (pcnt_added != '0));
  end

  always_comb begin
    col_nxt  = col_r;
    sum_nxt  = sum_r;
    row_nxt  = row_r;
    last_nxt = last_r;
    have_nxt = have_r;
    pcnt_nxt = pcnt_r;
    ovf_nxt  = ovf_r;
    if (pix_accept) begin
      if (!row_end) begin
        col_nxt = col_inc[ROW_W-1:0];
        sum_nxt = sum_acc;
      end else begin
        col_nxt = '0;
        sum_nxt = '0;
        ovf_nxt = ovf_r | (want_add & ~can_add);
        if (img_end) begin
          row_nxt  = '0;
          last_nxt = '0;
          have_nxt = 1'b0;
          pcnt_nxt = '0;
        end else begin
          row_nxt  = row_inc[ROW_W-1:0];
          pcnt_nxt = bright ? '0 : pcnt_added;
          if (do_add) begin
            last_nxt = row_r;
            have_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      sum_r  <= '0;
      row_r  <= '0;
      last_r <= '0;
      have_r <= 1'b0;
      pcnt_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      sum_r  <= sum_nxt;
      row_r  <= row_nxt;
      last_r <= last_nxt;
      have_r <= have_nxt;
      pcnt_r <= pcnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_comb begin
    ev_push     = pix_accept && row_end && (do_add || flush);
    ev.add      = do_add;
    ev.flush    = flush;
    ev.row      = row_r;
    ev.base     = bright ? row_ext : h;
    ev.overflow = ovf_nxt;
  end

endmodule

/* hw/rtl/drlf_evq.sv */
// drlf_evq: short event queue between classifier front and emitter back
// depends on drlf_pkg
module drlf_evq #(
  parameter int Depth = drlf_pkg::EVQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  drlf_pkg::event_t push_ev,
  input  logic             pop,
  output drlf_pkg::event_t head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  drlf_pkg::event_t mem [Depth];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign empty   = cnt_r == '0;
  assign full    = cnt_r == CNT_W'(Depth);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(Depth - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(Depth - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

/* hw/rtl/drlf_back.sv */
// drlf_back: holds pending line starts and sweeps them out one beat per cycle
// while out_line is ready; pops drlf_evq; depends on drlf_pkg, drlf_line_if
module drlf_back #(
  parameter int MaxPending = drlf_pkg::MAX_PENDING
) (
  input  logic             clk,
  input  logic             rst_n,
  input  drlf_pkg::event_t head,
  input  logic             q_empty,
  output logic             pop,
  drlf_line_if.source      out_line
);

  localparam int CNT_W = $clog2(MaxPending + 1);
  localparam int IDX_W = (MaxPending > 1) ? $clog2(MaxPending) : 1;
  localparam int ROW_W = drlf_pkg::ROW_W;
  localparam int DIM_W = drlf_pkg::DIM_W;

  drlf_pkg::back_state_t state_r, state_nxt;

  logic [ROW_W-1:0] starts [MaxPending];
  logic [CNT_W-1:0] bcnt_r, n_r;
  logic [IDX_W-1:0] idx_r;
  logic [DIM_W-1:0] base_r;
  logic             ovf_r;

  logic             out_valid_r;
  logic [ROW_W-1:0] out_start_r;
  logic [DIM_W-1:0] out_thick_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic             slot_free, last_beat, load;
  logic [ROW_W-1:0] cur_start;
  logic [DIM_W-1:0] cur_ext, cur_thick;

  always_comb begin
    slot_free = !out_valid_r || out_line.ready;
    last_beat = (CNT_W'(idx_r) + CNT_W'(1)) == n_r;
    cur_start = starts[idx_r];
    cur_ext   = DIM_W'(cur_start);
    cur_thick = (base_r > cur_ext) ? base_r - cur_ext : DIM_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      drlf_pkg::BK_IDLE: begin
        if (!q_empty && head.flush) state_nxt = drlf_pkg::BK_EMIT;
      end
      drlf_pkg::BK_EMIT: begin
        if (slot_free && last_beat) state_nxt = drlf_pkg::BK_IDLE;
      end
      default: state_nxt = drlf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state_r)
      drlf_pkg::BK_IDLE: pop  = !q_empty;
      drlf_pkg::BK_EMIT: load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && head.add) begin
      starts[bcnt_r[IDX_W-1:0]] <= head.row;
    end
    if (pop) begin
      base_r <= head.base;
      ovf_r  <= head.overflow;
    end
    if (load) begin
      out_start_r <= cur_start;
      out_thick_r <= cur_thick;
      out_last_r  <= last_beat;
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drlf_pkg::BK_IDLE;
      bcnt_r      <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        bcnt_r <= bcnt_r + CNT_W'(head.add);
        n_r    <= bcnt_r + CNT_W'(head.add);
        idx_r  <= '0;
      end
      if (load) begin
        idx_r <= idx_r + IDX_W'(1);
        if (last_beat) bcnt_r <= '0;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_line.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_line.valid          = out_valid_r;
  assign out_line.line_start     = out_start_r;
  assign out_line.line_thickness = out_thick_r;
  assign out_line.last_of_run    = out_last_r;
  assign out_line.overflow       = out_ovf_r;

endmodule

/* hw/rtl/dark_row_line_finder.sv */
// dark_row_line_finder: top level, config registers and the front/queue/back chain
// depends on drlf_pkg, drlf_pix_if, drlf_line_if, drlf_front, drlf_evq, drlf_back
//
// usage
//   in_pix carries one 8-bit pixel per beat in raster order. a row ends after
//   image_width beats; its sum is classified and at most one event goes into a
//   four-entry queue. out_line carries one line per beat: start row, thickness,
//   overflow flag and last_of_run on the final beat caused by the same pixel.
//   cfg_we/cfg_index/cfg_data write one register per cycle; the user writes only while idle, unenforced.
// timing
//   pixels are taken one per cycle while the event queue has room; in_pix.ready
//   drops only when the queue is full. the row-ending event passes the queue, the
//   emitter takes it from the queue in its idle state and registers the first line
//   in its emit state, then one line per cycle while out_line is ready; a burst
//   occupies the emitter until its last line is loaded.
// reset and stall
//   rst_n (synchronous) restores register defaults and clears counters, queue
//   and the overflow flag; stored starts are not cleared, none is read unwritten.
//   a stalled out_line holds its beat; the queue absorbs further rows until full.
module dark_row_line_finder #(
  parameter int MaxPending = drlf_pkg::MAX_PENDING
) (
  input  logic                            clk,
  input  logic                            rst_n,
  drlf_pix_if.sink                        in_pix,
  drlf_line_if.source                     out_line,
  input  logic                            cfg_we,
  input  logic [drlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drlf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_W = drlf_pkg::DIM_W;
  localparam int SUM_W = drlf_pkg::SUM_W;
  localparam int GAP_W = drlf_pkg::GAP_W;

  drlf_pkg::cfg_t   cfg_r;
  drlf_pkg::event_t push_ev, head;
  logic             push, pop, q_empty, q_full, pix_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width       <= drlf_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height      <= drlf_pkg::RST_IMAGE_HEIGHT;
      cfg_r.dark_threshold    <= drlf_pkg::RST_DARK_THRESHOLD;
      cfg_r.bright_threshold  <= drlf_pkg::RST_BRIGHT_THRESHOLD;
      cfg_r.top_band_limit    <= drlf_pkg::RST_TOP_BAND_LIMIT;
      cfg_r.bottom_band_limit <= drlf_pkg::RST_BOTTOM_BAND_LIMIT;
      cfg_r.min_line_gap      <= drlf_pkg::RST_MIN_LINE_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drlf_pkg::CFG_IMAGE_WIDTH:       cfg_r.image_width       <= cfg_data[DIM_W-1:0];
        drlf_pkg::CFG_IMAGE_HEIGHT:      cfg_r.image_height      <= cfg_data[DIM_W-1:0];
        drlf_pkg::CFG_DARK_THRESHOLD:    cfg_r.dark_threshold    <= cfg_data[SUM_W-1:0];
        drlf_pkg::CFG_BRIGHT_THRESHOLD:  cfg_r.bright_threshold  <= cfg_data[SUM_W-1:0];
        drlf_pkg::CFG_TOP_BAND_LIMIT:    cfg_r.top_band_limit    <= cfg_data[DIM_W-1:0];
        drlf_pkg::CFG_BOTTOM_BAND_LIMIT: cfg_r.bottom_band_limit <= cfg_data[DIM_W-1:0];
        drlf_pkg::CFG_MIN_LINE_GAP:      cfg_r.min_line_gap      <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.ready = !q_full;
  assign pix_accept   = in_pix.valid && !q_full;

  drlf_front #(
    .MaxPending (MaxPending)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pix_accept (pix_accept),
    .pixel      (in_pix.pixel),
    .ev         (push_ev),
    .ev_push    (push)
  );

  drlf_evq #(
    .Depth (drlf_pkg::EVQ_DEPTH)
  ) u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  drlf_back #(
    .MaxPending (MaxPending)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_line (out_line)
  );

endmodule

/* hw/rtl/drlf_checker.sv */
// drlf_checker: port-level assertions for dark_row_line_finder, bound to the top
// depends on drlf_pkg
module drlf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [drlf_pkg::ROW_W-1:0] out_line_start,
  input logic [drlf_pkg::DIM_W-1:0] out_line_thickness,
  input logic                       out_last_of_run,
  input logic                       out_overflow
);

  // no beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out beat valid right after reset");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_start) &&
      $stable(out_line_thickness) && $stable(out_last_of_run) && $stable(out_overflow))
    else $error("stalled out beat changed");

  a_thick_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_thickness != '0 &&
      out_line_thickness <= drlf_pkg::DIM_W'(drlf_pkg::MAX_DIM))
    else $error("line thickness out of range");

  // a burst continues in the next cycle with the same overflow flag
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=>
      out_valid && (out_overflow == $past(out_overflow)))
    else $error("line burst broken or overflow flag changed within burst");

endmodule

bind dark_row_line_finder drlf_checker u_drlf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_line.valid),
  .out_ready          (out_line.ready),
  .out_line_start     (out_line.line_start),
  .out_line_thickness (out_line.line_thickness),
  .out_last_of_run    (out_line.last_of_run),
  .out_overflow       (out_line.overflow)
);
